// ===== sv/input_latency_ticket_table_defines.svh =====
// Assertion macros used by the ticket table RTL.
`ifndef INPUT_LATENCY_TICKET_TABLE_DEFINES_SVH
`define INPUT_LATENCY_TICKET_TABLE_DEFINES_SVH
`ifndef SYNTH
`define ILTT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ticket table assertion failed");
`define ILTT_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ticket table assertion failed");
`else
`define ILTT_ASSERT_IMP(label, clk, rstn, ante, cons)
`define ILTT_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/iltt_pkg.sv =====
`timescale 1ns / 1ps
package iltt_pkg;
    localparam int SLOTS = 16;
    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        ST_EMPTY      = 2'd0,
        ST_ACCEPTED   = 2'd1,
        ST_DISPATCHED = 2'd2
    } slot_status_t;

    localparam logic [2:0] OP_ACCEPT   = 3'd0;
    localparam logic [2:0] OP_CANCEL   = 3'd1;
    localparam logic [2:0] OP_DISPATCH = 3'd2;
    localparam logic [2:0] OP_PRESENT  = 3'd3;
    localparam logic [2:0] OP_EXPIRE   = 3'd4;

    localparam logic [2:0] KIND_ACCEPTED  = 3'd0;
    localparam logic [2:0] KIND_DROPPED   = 3'd1;
    localparam logic [2:0] KIND_PRESENTED = 3'd2;
    localparam logic [2:0] KIND_LATENCY   = 3'd3;
    localparam logic [2:0] KIND_UNTRACKED = 3'd4;

    localparam logic [1:0] REASON_TIMEOUT  = 2'd0;
    localparam logic [1:0] REASON_OVERFLOW = 2'd1;
    localparam logic [1:0] REASON_CANCEL   = 2'd2;

    typedef struct packed {
        slot_status_t status;
        logic [63:0]  stamp;
        logic [31:0]  epoch;
        logic [15:0]  id;
        logic [15:0]  action;
    } slot_t;

    typedef struct packed {
        logic             st_we;
        logic             ent_we;
        logic [IDX_W-1:0] idx;
        slot_status_t     status;
        logic [63:0]      stamp;
        logic [31:0]      epoch;
        logic [15:0]      id;
        logic [15:0]      action;
    } slot_wr_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] stamp;
        logic [15:0] id;
        logic [31:0] epoch;
        logic [3:0]  act;
        logic [1:0]  reason;
        logic [31:0] lat;
    } result_t;
endpackage

// ===== sv/input_latency_ticket_table.sv =====
`timescale 1ns / 1ps
// An item is taken in S_IDLE, then each table walk visits the slots one at a time.
// Accept sweeps expired slots, then seeks a free one; present sweeps, then reports tickets.
// The walks share one 64-bit age subtractor; results wait when m_ready is low.
// One item is in work at a time; s_ready is high only between items.
// Synchronous active-low reset empties all slots and clears the id counter.
`include "input_latency_ticket_table_defines.svh"
module input_latency_ticket_table
    import iltt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [15:0] s_action,
    input  logic        s_pressed,
    input  logic [15:0] s_ticket_id,
    input  logic [63:0] s_now_us,
    input  logic [31:0] s_epoch,
    input  logic        s_tracing_on,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [63:0] m_stamp_us,
    output logic [15:0] m_id_out,
    output logic [31:0] m_epoch_out,
    output logic [3:0]  m_action_bits,
    output logic [1:0]  m_drop_reason,
    output logic [31:0] m_latency_us,
    output logic        m_last
);
    typedef enum logic [3:0] {
        S_IDLE, S_EXPIRE, S_NT, S_ALLOC, S_ACC, S_OVF, S_CANCEL, S_DISP,
        S_DCOMMIT, S_PMARK, S_PSEL, S_PPICK, S_PEMIT1, S_PEMIT2, S_FLUSH
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next, cnt_reg, cnt_next;
    logic [IDX_W-1:0] alloc_reg, alloc_next, sel_idx_reg, sel_idx_next;
    logic [2:0]       op_reg, op_next;
    logic [15:0]      act_reg, act_next, tid_reg, tid_next;
    logic [63:0]      now_reg, now_next, sel_stamp_reg, sel_stamp_next;
    logic [31:0]      ep_reg, ep_next, timeout_reg, timeout_next;
    logic             tr_reg, tr_next;
    logic [15:0]      idctr_reg, idctr_next, newid_reg, newid_next;
    logic [15:0]      sel_id_reg, sel_id_next;
    logic             placed_reg, placed_next, found_reg, found_next;
    logic [SLOTS-1:0] pmask_reg, pmask_next;
    logic             pend_valid_reg, pend_valid_next;
    result_t          pend_reg, pend_next, m_res_reg, m_res_next;
    logic             m_valid_reg, m_valid_next, m_last_reg, m_last_next;

    slot_wr_t         wr;
    slot_t            e;
    logic             timed, occ, better, gen, go, out_free, last_idx;
    logic [31:0]      lat;
    logic [15:0]      nid;
    logic [IDX_W-1:0] idx_wrap;
    result_t          res;

    iltt_slots u_slots (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .rd_idx  (idx_reg),
        .rd      (e)
    );

    iltt_age_unit u_age (
        .now_us     (now_reg),
        .stamp      (e.stamp),
        .timeout_us (timeout_reg),
        .timed      (timed),
        .lat        (lat)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        occ      = (e.status != ST_EMPTY);
        last_idx = (idx_reg == IDX_LAST);
        idx_wrap = last_idx ? '0 : idx_reg + 1'b1;
        better   = !found_reg || (e.stamp < sel_stamp_reg) ||
                   (e.stamp == sel_stamp_reg && e.id < sel_id_reg);
        nid      = idctr_reg + 16'd1;
        if (nid == 16'd0) begin
            nid = 16'd1;
        end

        gen = 1'b0;
        res = '{kind: KIND_DROPPED, stamp: now_reg, id: e.id, epoch: e.epoch,
                act: e.action[3:0], reason: REASON_TIMEOUT, lat: 32'd0};
        case (state_reg)
            S_EXPIRE: begin
                gen = occ && (e.epoch == ep_reg) && timed;
            end
            S_NT: begin
                gen = 1'b1;
                res = '0;
                res.kind = KIND_UNTRACKED;
            end
            S_ACC, S_OVF: begin
                gen        = 1'b1;
                res.kind   = (state_reg == S_ACC) ? KIND_ACCEPTED : KIND_DROPPED;
                res.reason = (state_reg == S_ACC) ? REASON_TIMEOUT : REASON_OVERFLOW;
                res.id     = newid_reg;
                res.epoch  = ep_reg;
                res.act    = act_reg[3:0];
            end
            S_CANCEL: begin
                gen = (e.status == ST_ACCEPTED) && (e.id == tid_reg) && tr_reg &&
                      (e.epoch == ep_reg);
                res.reason = REASON_CANCEL;
            end
            S_PEMIT1: begin
                gen      = 1'b1;
                res.kind = KIND_PRESENTED;
            end
            S_PEMIT2: begin
                gen      = 1'b1;
                res.kind = KIND_LATENCY;
                res.lat  = lat;
            end
            default: begin
                gen = 1'b0;
            end
        endcase
        go = !gen || !pend_valid_reg || out_free;

        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        alloc_next     = alloc_reg;
        sel_idx_next   = sel_idx_reg;
        op_next        = op_reg;
        act_next       = act_reg;
        tid_next       = tid_reg;
        now_next       = now_reg;
        sel_stamp_next = sel_stamp_reg;
        ep_next        = ep_reg;
        tr_next        = tr_reg;
        timeout_next   = cfg_valid ? cfg_data : timeout_reg;
        idctr_next     = idctr_reg;
        newid_next     = newid_reg;
        sel_id_next    = sel_id_reg;
        placed_next    = placed_reg;
        found_next     = found_reg;
        pmask_next     = pmask_reg;
        pend_valid_next = pend_valid_reg;
        pend_next      = pend_reg;
        m_res_next     = m_res_reg;
        m_last_next    = m_last_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        wr             = '0;
        wr.idx         = idx_reg;
        wr.status      = ST_EMPTY;
        wr.stamp       = now_reg;
        wr.epoch       = ep_reg;
        wr.id          = newid_reg;
        wr.action      = act_reg;

        if (gen && go) begin
            if (pend_valid_reg) begin
                m_res_next   = pend_reg;
                m_last_next  = 1'b0;
                m_valid_next = 1'b1;
            end
            pend_next       = res;
            pend_valid_next = 1'b1;
        end

        if (go) begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_next   = s_operation;
                        act_next  = s_action;
                        tid_next  = s_ticket_id;
                        now_next  = s_now_us;
                        ep_next   = s_epoch;
                        tr_next   = s_tracing_on;
                        idx_next  = '0;
                        found_next = 1'b0;
                        state_next = S_FLUSH;
                        case (s_operation)
                            OP_ACCEPT: begin
                                state_next = s_tracing_on ? S_EXPIRE : S_NT;
                            end
                            OP_CANCEL: begin
                                if (s_ticket_id != 16'd0) begin
                                    state_next = S_CANCEL;
                                end
                            end
                            OP_DISPATCH: begin
                                if (s_pressed && s_tracing_on) begin
                                    state_next = S_DISP;
                                end
                            end
                            OP_PRESENT, OP_EXPIRE: begin
                                if (s_tracing_on) begin
                                    state_next = S_EXPIRE;
                                end
                            end
                            default: begin
                                state_next = S_FLUSH;
                            end
                        endcase
                    end
                end
                S_EXPIRE: begin
                    if (occ && ((e.epoch != ep_reg) || timed)) begin
                        wr.st_we = 1'b1;
                    end
                    idx_next = idx_wrap;
                    if (last_idx) begin
                        case (op_reg)
                            OP_ACCEPT: begin
                                state_next  = S_ALLOC;
                                idx_next    = alloc_reg;
                                cnt_next    = '0;
                                alloc_next  = (alloc_reg == IDX_LAST) ? '0 : alloc_reg + 1'b1;
                                idctr_next  = nid;
                                newid_next  = nid;
                                placed_next = 1'b0;
                            end
                            OP_PRESENT: begin
                                state_next = S_PMARK;
                                pmask_next = '0;
                            end
                            default: begin
                                state_next = S_FLUSH;
                            end
                        endcase
                    end
                end
                S_NT: begin
                    state_next = S_FLUSH;
                end
                S_ALLOC: begin
                    if (e.status == ST_EMPTY) begin
                        wr.st_we    = 1'b1;
                        wr.ent_we   = 1'b1;
                        wr.status   = ST_ACCEPTED;
                        placed_next = 1'b1;
                        state_next  = S_ACC;
                    end else if (cnt_reg == IDX_LAST) begin
                        state_next = S_ACC;
                    end else begin
                        idx_next = idx_wrap;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                S_ACC: begin
                    state_next = placed_reg ? S_FLUSH : S_OVF;
                end
                S_OVF: begin
                    state_next = S_FLUSH;
                end
                S_CANCEL: begin
                    if (e.status == ST_ACCEPTED && e.id == tid_reg) begin
                        wr.st_we   = 1'b1;
                        state_next = S_FLUSH;
                    end else if (last_idx) begin
                        state_next = S_FLUSH;
                    end else begin
                        idx_next = idx_wrap;
                    end
                end
                S_DISP: begin
                    if (e.status == ST_ACCEPTED && e.epoch == ep_reg &&
                        e.action == act_reg && better) begin
                        found_next     = 1'b1;
                        sel_idx_next   = idx_reg;
                        sel_stamp_next = e.stamp;
                        sel_id_next    = e.id;
                    end
                    idx_next = idx_wrap;
                    if (last_idx) begin
                        state_next = S_DCOMMIT;
                    end
                end
                S_DCOMMIT: begin
                    wr.st_we   = found_reg;
                    wr.idx     = sel_idx_reg;
                    wr.status  = ST_DISPATCHED;
                    state_next = S_FLUSH;
                end
                S_PMARK: begin
                    if (e.status == ST_DISPATCHED) begin
                        wr.st_we = 1'b1;
                        if (e.epoch == ep_reg) begin
                            pmask_next[idx_reg] = 1'b1;
                        end
                    end
                    idx_next = idx_wrap;
                    if (last_idx) begin
                        state_next = S_PSEL;
                        found_next = 1'b0;
                    end
                end
                S_PSEL: begin
                    if (pmask_reg[idx_reg] && better) begin
                        found_next     = 1'b1;
                        sel_idx_next   = idx_reg;
                        sel_stamp_next = e.stamp;
                        sel_id_next    = e.id;
                    end
                    idx_next = idx_wrap;
                    if (last_idx) begin
                        state_next = S_PPICK;
                    end
                end
                S_PPICK: begin
                    if (found_reg) begin
                        idx_next   = sel_idx_reg;
                        state_next = S_PEMIT1;
                    end else begin
                        state_next = S_FLUSH;
                    end
                end
                S_PEMIT1: begin
                    state_next = S_PEMIT2;
                end
                S_PEMIT2: begin
                    pmask_next[idx_reg] = 1'b0;
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = S_PSEL;
                end
                S_FLUSH: begin
                    if (!pend_valid_reg) begin
                        state_next = S_IDLE;
                    end else if (out_free) begin
                        m_res_next      = pend_reg;
                        m_last_next     = 1'b1;
                        m_valid_next    = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = S_IDLE;
                    end
                end
                default: begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            alloc_reg      <= '0;
            idctr_reg      <= 16'd0;
            timeout_reg    <= 32'd1000000;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            found_reg      <= 1'b0;
            placed_reg     <= 1'b0;
            pmask_reg      <= '0;
        end else begin
            state_reg      <= state_next;
            alloc_reg      <= alloc_next;
            idctr_reg      <= idctr_next;
            timeout_reg    <= timeout_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            found_reg      <= found_next;
            placed_reg     <= placed_next;
            pmask_reg      <= pmask_next;
        end
        idx_reg       <= idx_next;
        cnt_reg       <= cnt_next;
        sel_idx_reg   <= sel_idx_next;
        op_reg        <= op_next;
        act_reg       <= act_next;
        tid_reg       <= tid_next;
        now_reg       <= now_next;
        sel_stamp_reg <= sel_stamp_next;
        ep_reg        <= ep_next;
        tr_reg        <= tr_next;
        newid_reg     <= newid_next;
        sel_id_reg    <= sel_id_next;
        pend_reg      <= pend_next;
        m_res_reg     <= m_res_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_res_reg.kind;
    assign m_stamp_us    = m_res_reg.stamp;
    assign m_id_out      = m_res_reg.id;
    assign m_epoch_out   = m_res_reg.epoch;
    assign m_action_bits = m_res_reg.act;
    assign m_drop_reason = m_res_reg.reason;
    assign m_latency_us  = m_res_reg.lat;
    assign m_last        = m_last_reg;

    `ILTT_ASSERT_IMP(a_idle_nothing_held, aclk, aresetn, s_ready, !pend_valid_reg)
    `ILTT_ASSERT_NXT(a_take_leaves_idle, aclk, aresetn, s_valid && s_ready, state_reg != S_IDLE)
    `ILTT_ASSERT_IMP(a_new_id_nonzero, aclk, aresetn, state_reg == S_ACC, newid_reg != 16'd0)
    `ILTT_ASSERT_IMP(a_emit_is_marked, aclk, aresetn, state_reg == S_PEMIT1, pmask_reg[idx_reg])
endmodule

// ===== sv/iltt_slots.sv =====
`timescale 1ns / 1ps
module iltt_slots
    import iltt_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  slot_wr_t         wr,
    input  logic [IDX_W-1:0] rd_idx,
    output slot_t            rd
);
    slot_status_t status_reg [SLOTS];
    logic [63:0]  stamp_reg  [SLOTS];
    logic [31:0]  epoch_reg  [SLOTS];
    logic [15:0]  id_reg     [SLOTS];
    logic [15:0]  action_reg [SLOTS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                status_reg[i] <= ST_EMPTY;
            end
        end else if (wr.st_we) begin
            status_reg[wr.idx] <= wr.status;
        end
        if (wr.ent_we) begin
            stamp_reg[wr.idx]  <= wr.stamp;
            epoch_reg[wr.idx]  <= wr.epoch;
            id_reg[wr.idx]     <= wr.id;
            action_reg[wr.idx] <= wr.action;
        end
    end

    assign rd.status = status_reg[rd_idx];
    assign rd.stamp  = stamp_reg[rd_idx];
    assign rd.epoch  = epoch_reg[rd_idx];
    assign rd.id     = id_reg[rd_idx];
    assign rd.action = action_reg[rd_idx];
endmodule

// ===== sv/iltt_age_unit.sv =====
`timescale 1ns / 1ps
module iltt_age_unit
    import iltt_pkg::*;
(
    input  logic [63:0] now_us,
    input  logic [63:0] stamp,
    input  logic [31:0] timeout_us,
    output logic        timed,
    output logic [31:0] lat
);
    logic [64:0] diff;

    always_comb begin
        diff  = {1'b0, now_us} - {1'b0, stamp};
        timed = !diff[64] && (diff[63:0] >= {32'b0, timeout_us});
        if (diff[64] || diff[63:0] == 64'd0) begin
            lat = 32'd0;
        end else if (diff[63:32] != 32'd0) begin
            lat = 32'hffff_ffff;
        end else begin
            lat = diff[31:0];
        end
    end
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import iltt_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_operation = '0;
    logic [15:0] s_action = '0;
    logic        s_pressed = 1'b0;
    logic [15:0] s_ticket_id = '0;
    logic [63:0] s_now_us = '0;
    logic [31:0] s_epoch = '0;
    logic        s_tracing_on = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_kind;
    logic [63:0] m_stamp_us;
    logic [15:0] m_id_out;
    logic [31:0] m_epoch_out;
    logic [3:0]  m_action_bits;
    logic [1:0]  m_drop_reason;
    logic [31:0] m_latency_us;
    logic        m_last;

    input_latency_ticket_table dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_action(s_action), .s_pressed(s_pressed), .s_ticket_id(s_ticket_id),
        .s_now_us(s_now_us), .s_epoch(s_epoch), .s_tracing_on(s_tracing_on),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_stamp_us(m_stamp_us), .m_id_out(m_id_out), .m_epoch_out(m_epoch_out),
        .m_action_bits(m_action_bits), .m_drop_reason(m_drop_reason),
        .m_latency_us(m_latency_us), .m_last(m_last)
    );

    typedef struct packed {
        result_t r;
        logic    last;
    } event_t;

    event_t       pending_events[$];
    slot_status_t tk_status[SLOTS];
    logic [63:0]  tk_stamp[SLOTS];
    logic [31:0]  tk_epoch[SLOTS];
    logic [15:0]  tk_id[SLOTS];
    logic [15:0]  tk_action[SLOTS];
    int           next_slot;
    logic [15:0]  last_id;
    logic [31:0]  timeout_val;
    logic [63:0]  clock_us;
    logic [31:0]  cur_epoch;
    int           mismatches;
    int           idle_cycles;
    bit           hold_off;

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic event_t mk(logic [2:0] k, logic [63:0] st, logic [15:0] id,
                                  logic [31:0] ep, logic [15:0] act, logic [1:0] rs,
                                  logic [31:0] lat);
        event_t e;
        e.r.kind = k;
        e.r.stamp = st;
        e.r.id = id;
        e.r.epoch = ep;
        e.r.act = act[3:0];
        e.r.reason = rs;
        e.r.lat = lat;
        e.last = 1'b0;
        return e;
    endfunction

    function automatic bit is_older(int a, int b);
        if (tk_stamp[a] != tk_stamp[b]) return tk_stamp[a] < tk_stamp[b];
        if (tk_id[a] != tk_id[b]) return tk_id[a] < tk_id[b];
        return a < b;
    endfunction

    task automatic sweep_expired(logic [63:0] now, logic [31:0] ep, ref event_t q[$]);
        bit stale;
        bit timed;
        for (int i = 0; i < SLOTS; i++) begin
            if (tk_status[i] == ST_EMPTY) continue;
            stale = tk_epoch[i] != ep;
            timed = now >= tk_stamp[i] && (now - tk_stamp[i]) >= {32'd0, timeout_val};
            if (!stale && !timed) continue;
            if (!stale) q.push_back(mk(KIND_DROPPED, now, tk_id[i], tk_epoch[i],
                                       tk_action[i], REASON_TIMEOUT, '0));
            tk_status[i] = ST_EMPTY;
        end
    endtask

    task automatic predict_tickets(logic [2:0] op, logic [15:0] act, logic prs,
                                   logic [15:0] tid, logic [63:0] now, logic [31:0] ep,
                                   logic tr);
        event_t q[$];
        int     order[$];
        int     sel;
        int     s;
        int     k;
        bit     placed;
        logic [63:0] lat;
        case (op)
            OP_ACCEPT: begin
                if (!tr) begin
                    q.push_back(mk(KIND_UNTRACKED, '0, '0, '0, '0, '0, '0));
                end else begin
                    sweep_expired(now, ep, q);
                    last_id = last_id + 16'd1;
                    if (last_id == 16'd0) last_id = 16'd1;
                    placed = 1'b0;
                    for (int o = 0; o < SLOTS && !placed; o++) begin
                        s = (next_slot + o) % SLOTS;
                        if (tk_status[s] != ST_EMPTY) continue;
                        tk_stamp[s] = now;
                        tk_epoch[s] = ep;
                        tk_id[s] = last_id;
                        tk_action[s] = act;
                        tk_status[s] = ST_ACCEPTED;
                        placed = 1'b1;
                    end
                    next_slot = (next_slot + 1) % SLOTS;
                    q.push_back(mk(KIND_ACCEPTED, now, last_id, ep, act, '0, '0));
                    if (!placed) q.push_back(mk(KIND_DROPPED, now, last_id, ep, act,
                                                REASON_OVERFLOW, '0));
                end
            end
            OP_CANCEL: begin
                if (tid != 16'd0) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (tk_status[i] != ST_ACCEPTED || tk_id[i] != tid) continue;
                        if (tr && tk_epoch[i] == ep)
                            q.push_back(mk(KIND_DROPPED, now, tk_id[i], tk_epoch[i],
                                           tk_action[i], REASON_CANCEL, '0));
                        tk_status[i] = ST_EMPTY;
                        break;
                    end
                end
            end
            OP_DISPATCH: begin
                if (prs && tr) begin
                    sel = -1;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (tk_status[i] != ST_ACCEPTED || tk_epoch[i] != ep ||
                            tk_action[i] != act) continue;
                        if (sel < 0 || is_older(i, sel)) sel = i;
                    end
                    if (sel >= 0) tk_status[sel] = ST_DISPATCHED;
                end
            end
            OP_PRESENT: begin
                if (tr) begin
                    sweep_expired(now, ep, q);
                    for (int i = 0; i < SLOTS; i++) begin
                        if (tk_status[i] != ST_DISPATCHED) continue;
                        tk_status[i] = ST_EMPTY;
                        if (tk_epoch[i] != ep) continue;
                        k = 0;
                        while (k < order.size() && !is_older(i, order[k])) k++;
                        order.insert(k, i);
                    end
                    foreach (order[j]) begin
                        s = order[j];
                        lat = 0;
                        if (now > tk_stamp[s]) begin
                            lat = now - tk_stamp[s];
                            if (lat > 64'hffffffff) lat = 64'hffffffff;
                        end
                        q.push_back(mk(KIND_PRESENTED, now, tk_id[s], tk_epoch[s],
                                       tk_action[s], '0, '0));
                        q.push_back(mk(KIND_LATENCY, now, tk_id[s], tk_epoch[s],
                                       tk_action[s], '0, lat[31:0]));
                    end
                end
            end
            OP_EXPIRE: begin
                if (tr) sweep_expired(now, ep, q);
            end
            default: ;
        endcase
        if (q.size() > 0) q[q.size() - 1].last = 1'b1;
        foreach (q[j]) pending_events.push_back(q[j]);
    endtask

    task automatic random_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        repeat (n) @(negedge aclk);
    endtask

    task automatic send_item(logic [2:0] op, logic [15:0] act, logic prs,
                             logic [15:0] tid, logic [63:0] now, logic [31:0] ep,
                             logic tr);
        s_operation = op;
        s_action = act;
        s_pressed = prs;
        s_ticket_id = tid;
        s_now_us = now;
        s_epoch = ep;
        s_tracing_on = tr;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_tickets(op, act, prs, tid, now, ep, tr);
        @(negedge aclk);
        s_valid = 1'b0;
        random_gap();
    endtask

    task automatic drain();
        while (pending_events.size() > 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    task automatic write_timeout(logic [31:0] val);
        drain();
        cfg_data = val;
        cfg_valid = 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        timeout_val = val;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic tick(int lo, int hi);
        clock_us = clock_us + $urandom_range(lo, hi);
    endtask

    task automatic test_directed();
        write_timeout(32'd1000);
        send_item(OP_ACCEPT, 16'h0000, 1'b0, '0, clock_us, cur_epoch, 1'b0);
        send_item(OP_ACCEPT, 16'hffff, 1'b1, '0, clock_us, cur_epoch, 1'b1);
        send_item(OP_ACCEPT, 16'h1234, 1'b0, '0, clock_us, cur_epoch, 1'b1);
        send_item(OP_ACCEPT, 16'h1234, 1'b0, '0, clock_us, cur_epoch, 1'b1);
        send_item(OP_DISPATCH, 16'h1234, 1'b0, '0, clock_us, cur_epoch, 1'b1);
        send_item(OP_DISPATCH, 16'h1234, 1'b1, '0, clock_us, cur_epoch, 1'b0);
        send_item(OP_DISPATCH, 16'h1234, 1'b1, '0, clock_us, cur_epoch, 1'b1);
        send_item(OP_DISPATCH, 16'hffff, 1'b1, '0, clock_us, cur_epoch, 1'b1);
        tick(100, 200);
        send_item(OP_PRESENT, '0, 1'b0, 16'hffff, clock_us, cur_epoch, 1'b1);
        send_item(OP_CANCEL, '0, 1'b0, 16'd0, clock_us, cur_epoch, 1'b1);
        send_item(OP_CANCEL, '0, 1'b0, 16'd3, clock_us, cur_epoch, 1'b1);
        send_item(OP_CANCEL, '0, 1'b0, 16'hffff, clock_us, cur_epoch, 1'b0);
        send_item(3'd5, 16'hffff, 1'b1, 16'hffff, '1, '1, 1'b1);
        send_item(3'd7, '0, 1'b0, '0, '0, '0, 1'b1);
        for (int i = 0; i < SLOTS + 2; i++)
            send_item(OP_ACCEPT, 16'(i), 1'b0, '0, clock_us, cur_epoch, 1'b1);
        tick(2000, 3000);
        send_item(OP_EXPIRE, '0, 1'b0, '0, clock_us, cur_epoch, 1'b1);
    endtask

    task automatic test_extremes();
        write_timeout(32'hffffffff);
        send_item(OP_ACCEPT, 16'h00a5, 1'b0, '0, 64'd0, 32'hffffffff, 1'b1);
        send_item(OP_DISPATCH, 16'h00a5, 1'b1, '0, '1, 32'hffffffff, 1'b1);
        send_item(OP_PRESENT, '0, 1'b0, '0, '1, 32'hffffffff, 1'b1);
        send_item(OP_ACCEPT, 16'h5a00, 1'b0, '0, '1, 32'h0, 1'b1);
        send_item(OP_DISPATCH, 16'h5a00, 1'b1, '0, '1, 32'h0, 1'b1);
        send_item(OP_PRESENT, '0, 1'b0, '0, 64'd5, 32'h0, 1'b1);
        send_item(OP_ACCEPT, 16'h0001, 1'b0, '0, 64'd10, 32'h1, 1'b1);
        send_item(OP_EXPIRE, '0, 1'b0, '0, 64'd10, 32'h2, 1'b1);
        write_timeout(32'd0);
        send_item(OP_ACCEPT, 16'h0007, 1'b0, '0, 64'd50, 32'h3, 1'b1);
        send_item(OP_EXPIRE, '0, 1'b0, '0, 64'd49, 32'h3, 1'b1);
        send_item(OP_EXPIRE, '0, 1'b0, '0, 64'd50, 32'h3, 1'b1);
        clock_us = 64'd1000;
    endtask

    task automatic test_random(int count);
        logic [2:0]  op;
        logic [15:0] act;
        logic [15:0] tid;
        int          p;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 29) == 0) cur_epoch = cur_epoch + 1;
            if ($urandom_range(0, 39) == 0) cur_epoch = $urandom;
            tick(0, ($urandom_range(0, 7) == 0) ? 1500 : 60);
            p = $urandom_range(0, 99);
            op = p < 40 ? OP_ACCEPT : p < 50 ? OP_CANCEL : p < 75 ? OP_DISPATCH :
                 p < 88 ? OP_PRESENT : p < 96 ? OP_EXPIRE : 3'($urandom_range(5, 7));
            act = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
            tid = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                  last_id - 16'($urandom_range(0, 4));
            if ($urandom_range(0, 19) == 0) clock_us = clock_us - $urandom_range(0, 100);
            send_item(op, act, $urandom_range(0, 4) != 0, tid, clock_us,
                      ($urandom_range(0, 15) == 0) ? $urandom : cur_epoch,
                      $urandom_range(0, 9) != 0);
        end
    endtask

    task automatic test_backpressure();
        drain();
        hold_off = 1'b1;
        for (int i = 0; i < 8; i++)
            send_item(OP_ACCEPT, 16'(i), 1'b0, '0, clock_us, cur_epoch, 1'b1);
        hold_off = 1'b0;
        drain();
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) tk_status[i] = ST_EMPTY;
        next_slot = 0;
        last_id = '0;
        timeout_val = 32'd1000000;
        clock_us = 64'd1000;
        cur_epoch = 32'd7;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_extremes();
        write_timeout(32'd500);
        test_random(60);
        test_backpressure();
        write_timeout(32'd3000);
        test_random(60);
        drain();
        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (300) @(negedge aclk);
                m_ready <= 1'b1;
                while (hold_off) @(negedge aclk);
            end else if ($urandom_range(0, 1) == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 6) == 0 ? $urandom_range(5, 30) : 0)
                    @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        event_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_events.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result kind %0d", m_kind);
            end else begin
                e = pending_events.pop_front();
                if (m_kind !== e.r.kind || m_stamp_us !== e.r.stamp ||
                    m_id_out !== e.r.id || m_epoch_out !== e.r.epoch ||
                    m_action_bits !== e.r.act || m_drop_reason !== e.r.reason ||
                    m_latency_us !== e.r.lat || m_last !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp %0d %0d %0d %0d %0d %0d %0d %0d",
                                 e.r.kind, e.r.stamp, e.r.id, e.r.epoch, e.r.act,
                                 e.r.reason, e.r.lat, e.last);
                        $display("         got %0d %0d %0d %0d %0d %0d %0d %0d",
                                 m_kind, m_stamp_us, m_id_out, m_epoch_out,
                                 m_action_bits, m_drop_reason, m_latency_us, m_last);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("tb: FAIL");
            $finish;
        end
    end
endmodule

// ===== input_latency_ticket_table.f =====
+incdir+sv
sv/iltt_pkg.sv
sv/iltt_slots.sv
sv/iltt_age_unit.sv
sv/input_latency_ticket_table.sv
test/tb.sv
